// ===== rtl/h74psd_pkg.sv =====
// ----------------------------------------------------------------------------
// h74psd_pkg - shared types and Hamming(7,4) helpers
// Queue entry layout, parity constants and the single-word corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package h74psd_pkg;

	// Parity contributed by each data bit of the nibble
	localparam logic [2:0] PAR_D0 = 3'd3;
	localparam logic [2:0] PAR_D1 = 3'd5;
	localparam logic [2:0] PAR_D2 = 3'd6;
	localparam logic [2:0] PAR_D3 = 3'd7;

	localparam int unsigned CODE_W  = 8;
	localparam int unsigned WORD_W  = 7;
	localparam int unsigned COUNT_W = 32;

	// Last position of a seven-byte group
	localparam logic [2:0] PHASE_LAST = 3'd6;

	// One classified byte, handed from front to back
	typedef struct packed {
		logic               has_data;
		logic [7:0]         data;
		logic               has_status;
		logic               fmt_err;
		logic [COUNT_W-1:0] count;
	} entry_t;

	function automatic logic [2:0] parity_of(input logic [3:0] nib);
		logic [2:0] p;
		p = 3'd0;
		if (nib[0]) p = p ^ PAR_D0;
		if (nib[1]) p = p ^ PAR_D1;
		if (nib[2]) p = p ^ PAR_D2;
		if (nib[3]) p = p ^ PAR_D3;
		return p;
	endfunction

	// Corrects a 7-bit word to the nearest codeword, returns its nibble
	function automatic logic [3:0] decode_word(input logic [WORD_W-1:0] word);
		logic [3:0] nib;
		logic [2:0] syn;
		nib = word[3:0];
		syn = parity_of(nib) ^ word[6:4];
		unique case (syn)
			PAR_D0:  nib[0] = ~nib[0];
			PAR_D1:  nib[1] = ~nib[1];
			PAR_D2:  nib[2] = ~nib[2];
			PAR_D3:  nib[3] = ~nib[3];
			default: nib = nib;
		endcase
		return nib;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/h74psd_front.sv =====
// ----------------------------------------------------------------------------
// h74psd_front - byte unpacker and classifier
// Tracks group phase, carry bits and pending nibble; builds one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module h74psd_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [7:0]              code_byte,
	input  wire logic                    final_byte,
	output h74psd_pkg::entry_t           entry,
	output logic                         push
);
	import h74psd_pkg::*;

	logic [2:0]         phase_q;
	logic [7:0]         carry_q;
	logic [3:0]         high_q;
	logic [COUNT_W-1:0] counter_q;

	logic [2:0]         n;
	logic [2:0]         phase_n;
	logic [7:0]         carry_n;
	logic [3:0]         high_n;
	logic [COUNT_W-1:0] counter_n;
	logic [7:0]         prev;
	logic [7:0]         word_w;
	logic [7:0]         hi_w;
	logic [3:0]         nib;
	logic [7:0]         data;
	logic               emit;
	logic               err;

	always_comb begin
		// unreachable phase 7 behaves as phase 0
		n       = (phase_q > PHASE_LAST) ? 3'd1 : phase_q + 3'd1;
		phase_n = n;
		carry_n = carry_q;
		high_n  = high_q;
		data    = 8'd0;
		emit    = 1'b0;
		prev    = 8'd0;
		word_w  = 8'd0;
		hi_w    = carry_q | {7'd0, code_byte[7]};
		nib     = 4'd0;
		if (n == 3'd7) begin
			data    = {decode_word(hi_w[6:0]), decode_word(code_byte[6:0])};
			emit    = 1'b1;
			carry_n = 8'd0;
			phase_n = 3'd0;
		end else begin
			prev    = (n == 3'd1) ? 8'd0 : carry_q;
			word_w  = prev | (code_byte >> n);
			nib     = decode_word(word_w[6:0]);
			carry_n = 8'(code_byte << (3'd7 - n));
			if (n[0]) begin
				high_n = nib;
			end else begin
				data = {high_q, nib};
				emit = 1'b1;
			end
		end
		counter_n = (emit && counter_q != '1) ? counter_q + 1'b1 : counter_q;
		err = (phase_n == 3'd1) || (phase_n == 3'd3) || (phase_n == 3'd5) ||
		      (phase_n != 3'd0 && carry_n[6:0] != 7'd0);
	end

	always_comb begin
		entry.has_data   = emit;
		entry.data       = data;
		entry.has_status = final_byte;
		entry.fmt_err    = err;
		entry.count      = counter_n;
		push             = accept && (emit || final_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 3'd0;
			carry_q   <= 8'd0;
			high_q    <= 4'd0;
			counter_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				phase_q   <= 3'd0;
				carry_q   <= 8'd0;
				high_q    <= 4'd0;
				counter_q <= '0;
			end else begin
				phase_q   <= phase_n;
				carry_q   <= carry_n;
				high_q    <= high_n;
				counter_q <= counter_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/h74psd_queue.sv =====
// ----------------------------------------------------------------------------
// h74psd_queue - small entry queue between front and back
// Register-based FIFO, first-word fall-through on the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module h74psd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire h74psd_pkg::entry_t wr_entry,
	input  wire logic              pop,
	output h74psd_pkg::entry_t     head,
	output logic                   full,
	output logic                   empty
);
	import h74psd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = (fill_q == CNT_FULL);
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/h74psd_back.sv =====
// ----------------------------------------------------------------------------
// h74psd_back - result expander and output register
// Turns each queue entry into a data transfer, a status transfer or both.
// ----------------------------------------------------------------------------
`default_nettype none

module h74psd_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire h74psd_pkg::entry_t    head,
	input  wire logic                  empty,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 data_byte,
	output logic                       is_status,
	output logic                       format_error,
	output logic [h74psd_pkg::COUNT_W-1:0] decoded_count
);
	import h74psd_pkg::*;

	logic               valid_q;
	logic               split_q;   // data half of a dual entry already shown
	logic [7:0]         data_q;
	logic               status_q;
	logic               err_q;
	logic [COUNT_W-1:0] count_q;

	logic load;
	logic show_data;
	logic last_of_entry;

	always_comb begin
		load          = (!valid_q || out_ready) && !empty;
		show_data     = head.has_data && !split_q;
		last_of_entry = !(show_data && head.has_status);
		pop           = load && last_of_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			split_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				split_q <= !last_of_entry;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= show_data ? head.data : 8'd0;
			status_q <= !show_data;
			err_q    <= show_data ? 1'b0 : head.fmt_err;
			count_q  <= show_data ? '0 : head.count;
		end
	end

	assign out_valid     = valid_q;
	assign data_byte     = data_q;
	assign is_status     = status_q;
	assign format_error  = err_q;
	assign decoded_count = count_q;

endmodule

`default_nettype wire

// ===== rtl/hamming74_packed_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// hamming74_packed_stream_decoder - packed Hamming(7,4) byte stream decoder
// Unpacks eight 7-bit codewords from every seven bytes, corrects each and
// emits one data byte per codeword pair, plus a status transfer per message.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields (tdata from bit 0 up)                       Marker
// s_*      in   tdata[7:0] code_byte                               tlast = final_byte
// m_*      out  tdata[7:0] data_byte, [8] format_error,            tlast = is_status
//               [40:9] decoded_count, [47:41] zero
//
// One byte is taken per cycle while s_tready is high; the front unpacks,
// corrects and counts in the cycle of the transfer, the entry is written
// into the queue, then loaded into the output register, and leaves once
// m_tready is high. A closing byte that also completes a data byte yields
// two output transfers, data first and then status, from one queue entry.
// s_tready falls only when the queue between front and back is full, which
// follows from back-pressure on the master side.
// arst_n clears phase, carry, nibble, counter, queue pointers and out valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming74_packed_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] code_byte
	input  wire logic        s_tlast,   // final_byte
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] data_byte, [8] format_error,
	                                    // [40:9] decoded_count, [47:41] zero
	output logic             m_tlast    // is_status
);
	import h74psd_pkg::*;

	entry_t             fr_entry;
	entry_t             q_head;
	logic               fr_push;
	logic               q_full;
	logic               q_empty;
	logic               bk_pop;
	logic               accept;
	logic [7:0]         data_byte;
	logic               format_error;
	logic [COUNT_W-1:0] decoded_count;

	// Every accepted byte pushes at most one entry, so space for one suffices
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	h74psd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_byte  (s_tdata),
		.final_byte (s_tlast),
		.entry      (fr_entry),
		.push       (fr_push)
	);

	h74psd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fr_push),
		.wr_entry (fr_entry),
		.pop      (bk_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	h74psd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (bk_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.data_byte     (data_byte),
		.is_status     (m_tlast),
		.format_error  (format_error),
		.decoded_count (decoded_count)
	);

	// pad to whole bytes
	assign m_tdata = {7'd0, decoded_count, format_error, data_byte};

endmodule

`default_nettype wire

// ===== tb/tb_hamming74_packed_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_hamming74_packed_stream_decoder - self-checking bench for the decoder
// Feeds packed Hamming(7,4) messages, both well-formed and noisy, with random
// gaps and back-pressure, and predicts every data and status transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hamming74_packed_stream_decoder;

	// nibble patterns and codeword corruption for generated messages
	localparam int NIB_RANDOM  = 0;
	localparam int NIB_EXTREME = 1;
	localparam int FLIP_NONE   = 0;
	localparam int FLIP_WALK   = 1;
	localparam int FLIP_RANDOM = 2;

	localparam int ITEM_TARGET = 450;
	localparam int CALM_TAIL   = 380;

	typedef struct {
		logic [7:0]                          data_byte;
		logic                                is_status;
		logic                                format_error;
		logic [h74psd_pkg::COUNT_W-1:0]      decoded_count;
	} decoded_item_t;

	// Tracks the unpacking state and holds the transfers still owed by the DUT
	class decode_checker;
		logic [2:0]  group_pos;
		logic [7:0]  leftover;
		logic [3:0]  upper_nib;
		logic [31:0] bytes_out;
		decoded_item_t pending_items[$];
		int unsigned fails;

		function new();
			group_pos = '0;
			leftover  = '0;
			upper_nib = '0;
			bytes_out = '0;
			fails     = 0;
		endfunction

		static function logic [6:0] code_of(input logic [3:0] n);
			return {n[1] ^ n[2] ^ n[3], n[0] ^ n[2] ^ n[3], n[0] ^ n[1] ^ n[3], n};
		endfunction

		// minimum-distance search; the code is perfect so one word always wins
		static function logic [3:0] nearest_nibble(input logic [6:0] word);
			logic [3:0] best;
			int best_dist;
			int d;
			best = '0;
			best_dist = 8;
			for (int v = 0; v < 16; v++) begin
				d = $countones(code_of(4'(v)) ^ word);
				if (d < best_dist) begin
					best_dist = d;
					best = 4'(v);
				end
			end
			return best;
		endfunction

		function void take_code_byte(input logic [7:0] b, input logic fin);
			int unsigned step;
			logic [7:0] word_bits;
			logic [3:0] hi;
			logic [3:0] lo;
			logic emit;
			logic [7:0] data;
			logic bad;
			decoded_item_t it;
			step = (group_pos > h74psd_pkg::PHASE_LAST) ? 1 : group_pos + 1;
			emit = 1'b0;
			data = '0;
			if (step == 7) begin
				// last byte of a group closes two codewords at once
				word_bits = leftover | (b >> 7);
				hi = nearest_nibble(word_bits[6:0]);
				lo = nearest_nibble(b[6:0]);
				data = {hi, lo};
				emit = 1'b1;
				leftover = '0;
				step = 0;
			end else begin
				word_bits = ((step == 1) ? 8'h00 : leftover) | (b >> step);
				lo = nearest_nibble(word_bits[6:0]);
				leftover = b << (7 - step);
				if (step % 2 == 1) begin
					upper_nib = lo;
				end else begin
					data = {upper_nib, lo};
					emit = 1'b1;
				end
			end
			group_pos = step[2:0];

			if (emit) begin
				if (bytes_out != '1)
					bytes_out++;
				it.data_byte     = data;
				it.is_status     = 1'b0;
				it.format_error  = 1'b0;
				it.decoded_count = '0;
				pending_items.push_back(it);
			end

			if (fin) begin
				// odd positions end mid-byte; even ones must have clean padding
				bad = (step == 1 || step == 3 || step == 5) ||
				      (step != 0 && leftover[6:0] != 7'd0);
				it.data_byte     = '0;
				it.is_status     = 1'b1;
				it.format_error  = bad;
				it.decoded_count = bytes_out;
				pending_items.push_back(it);
				group_pos = '0;
				leftover  = '0;
				upper_nib = '0;
				bytes_out = '0;
			end
		endfunction

		function void match_output(input logic [47:0] td, input logic tl);
			decoded_item_t ex;
			if (pending_items.size() == 0) begin
				fails++;
				$display("%0t: unexpected transfer, expected none actual tdata=%012h tlast=%b",
				         $time, td, tl);
				return;
			end
			ex = pending_items.pop_front();
			if (td[7:0] !== ex.data_byte) begin
				fails++;
				$display("%0t: data_byte expected %02h actual %02h",
				         $time, ex.data_byte, td[7:0]);
			end
			if (tl !== ex.is_status) begin
				fails++;
				$display("%0t: is_status expected %b actual %b", $time, ex.is_status, tl);
			end
			if (td[8] !== ex.format_error) begin
				fails++;
				$display("%0t: format_error expected %b actual %b",
				         $time, ex.format_error, td[8]);
			end
			if (td[40:9] !== ex.decoded_count) begin
				fails++;
				$display("%0t: decoded_count expected %0d actual %0d",
				         $time, ex.decoded_count, td[40:9]);
			end
			if (td[47:41] !== 7'd0) begin
				fails++;
				$display("%0t: tdata top bits expected 00 actual %02h", $time, td[47:41]);
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;

	decode_checker book;
	bit          bursts_on = 1'b1;
	int          stall_left = 0;
	int          bytes_sent = 0;

	hamming74_packed_stream_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Sink side: ready drops for random stretches while bursts are enabled
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (bursts_on && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 7);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every master-side transfer is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.match_output(m_tdata, m_tlast);
	end

	// Called and returns at a falling edge; the transfer is noted at the
	// rising edge where tvalid and tready are both seen high.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (bursts_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		book.take_code_byte(b, fin);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Encodes n_cw nibbles, packs them MSB first and pads to a whole byte
	task automatic send_coded(input int n_cw, input int flip_mode, input bit dirty_pad,
	                          input int nib_mode);
		bit stream[$];
		logic [6:0] cw;
		logic [3:0] nib;
		logic [7:0] b;
		int pad;
		int flip_at;
		for (int i = 0; i < n_cw; i++) begin
			if (nib_mode == NIB_EXTREME)
				nib = (i % 2 == 1) ? 4'hF : 4'h0;
			else
				nib = 4'($urandom_range(0, 15));
			cw = decode_checker::code_of(nib);
			// walking flip hits bit i of word i, the eighth word stays clean
			if (flip_mode == FLIP_WALK && (i % 8) < 7) begin
				cw[i % 8] = ~cw[i % 8];
			end else if (flip_mode == FLIP_RANDOM && $urandom_range(0, 2) == 0) begin
				flip_at = $urandom_range(0, 6);
				cw[flip_at] = ~cw[flip_at];
			end
			for (int k = 6; k >= 0; k--)
				stream.push_back(cw[k]);
		end
		pad = (8 - stream.size() % 8) % 8;
		for (int k = 0; k < pad; k++)
			stream.push_back(1'b0);
		if (dirty_pad && pad > 0)
			stream[stream.size() - 1 - $urandom_range(0, pad - 1)] = 1'b1;
		while (stream.size() > 0) begin
			for (int k = 7; k >= 0; k--)
				b[k] = stream.pop_front();
			send_byte(b, stream.size() == 0);
		end
	endtask

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int kind;
		int len;
		book = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: one-byte message ends mid-byte
		send_byte(8'hFF, 1'b1);
		// clean pair of extreme nibbles, then a pair with dirty padding
		send_coded(2, FLIP_NONE, 1'b0, NIB_EXTREME);
		send_coded(2, FLIP_RANDOM, 1'b1, NIB_RANDOM);
		// full group, single-bit error walked over every codeword bit
		send_coded(8, FLIP_WALK, 1'b0, NIB_RANDOM);
		// six bytes, ends after the sixth with clean padding
		send_coded(6, FLIP_NONE, 1'b0, NIB_EXTREME);
		// raw bytes: end on the third (mid-byte), then on the fourth
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h80, 1'b1);

		// random: mostly well-formed messages with corrupted words, some noise
		while (bytes_sent < ITEM_TARGET) begin
			if (bytes_sent > CALM_TAIL)
				bursts_on = 1'b0;
			else
				bursts_on = ($urandom_range(0, 4) != 0);
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				len = 2 * $urandom_range(1, 12);
				send_coded(len, FLIP_RANDOM, $urandom_range(0, 6) == 0, NIB_RANDOM);
			end else if (kind < 8) begin
				len = $urandom_range(1, 25);
				send_coded(len, FLIP_RANDOM, $urandom_range(0, 1) == 0, NIB_RANDOM);
			end else begin
				len = $urandom_range(1, 16);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(0, 255)), i == len - 1);
			end
		end
		s_tvalid <= 1'b0;
		bursts_on = 1'b0;

		while (book.pending_items.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (book.fails == 0 && book.pending_items.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
